// ===== rtl/core/nmeapos_pkg.sv =====
// Shared constants for the NMEA position field parser: character codes,
// coordinate limits and the decimal weight table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nmeapos_pkg;

    localparam int FRAC_DIGITS_DEF = 5;
    localparam int FIELD_W         = 4;
    localparam logic [FIELD_W-1:0] LAT_INDEX_RST = 4'd2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam int LAT_LIMIT = 900000000;
    localparam int LON_LIMIT = 1800000000;
    localparam int DEG_SCALE = 10000000;

    localparam int POW10_W = 24;

    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] e);
        logic [POW10_W-1:0] v;
        unique case (e)
            3'd0: v = 24'd1;
            3'd1: v = 24'd10;
            3'd2: v = 24'd100;
            3'd3: v = 24'd1000;
            3'd4: v = 24'd10000;
            3'd5: v = 24'd100000;
            3'd6: v = 24'd1000000;
            3'd7: v = 24'd10000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmea_position_field_parser_core.sv =====
// NMEA position field parser: byte-wise field scanner plus a five-stage
// fixed-point conversion pipeline from ddmm.fff to 1e-7 degree units.
// Depends on nmeapos_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one sentence character per cycle on s_axis when not stalled and, for
// each request with tlast set, returns one position on m_axis: latitude and
// longitude in signed 1e-7 degree units, truncated, south and west negative,
// clamped to +-90 and +-180 degrees, with tuser set when digits were dropped
// or a value clamped. After its tlast request is taken, a position passes
// through the five registered conversion stages (scale, constant multiply,
// reciprocal divide, add and clamp, sign), the last of which is the output
// register; they also buffer up to five positions, so the input stalls only
// when all of them wait on m_axis_tready. The latitude field number is to be
// written through the cfg channel only while idle; the block itself does not
// enforce this. It resets to 2.
module nmea_position_field_parser_core #(
    parameter int FRAC_DIGITS = nmeapos_pkg::FRAC_DIGITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // sentence_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [30:0] latitude, [62:31] longitude, [63] 0
    output logic             m_axis_tuser,   // format_flag
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data      // lat_field_index
);

    localparam int FR_W   = $clog2(10 ** FRAC_DIGITS);
    localparam int X_W    = 30;
    localparam int PROD_W = 30;
    localparam int RCP_W  = 31;
    localparam int Q_W    = 28;
    localparam int MAG_W  = 34;
    localparam int LATM_W = 30;
    localparam int LONM_W = 31;

    // minutes * 1e7 / 60 == X * MUL / DEN with X = minutes scaled by 10^FRAC_DIGITS
    localparam int MUL   = (FRAC_DIGITS <= 5) ? 5 * (10 ** (5 - FRAC_DIGITS)) : 1;
    localparam int DEN   = (FRAC_DIGITS <= 5) ? 3 : ((FRAC_DIGITS == 6) ? 6 : 60);
    localparam int SHIFT = PROD_W + $clog2(DEN);
    localparam longint unsigned RCP_L = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);

    localparam logic [X_W-1:0]    P_C    = X_W'(10 ** FRAC_DIGITS);
    localparam logic [PROD_W-1:0] MUL_C  = PROD_W'(MUL);
    localparam logic [RCP_W-1:0]  RCP_C  = RCP_W'(RCP_L);
    localparam logic [MAG_W-1:0]  DEG_C  = MAG_W'(nmeapos_pkg::DEG_SCALE);
    localparam logic [MAG_W-1:0]  LATL_C = MAG_W'(nmeapos_pkg::LAT_LIMIT);
    localparam logic [MAG_W-1:0]  LONL_C = MAG_W'(nmeapos_pkg::LON_LIMIT);
    localparam logic [2:0]        FD_C   = 3'(FRAC_DIGITS);
    localparam logic [2:0]        FDM1_C = 3'(FRAC_DIGITS - 1);

    // scanner state
    logic [3:0]      r_lat_idx;
    logic [3:0]      r_field,    n_field;
    logic [4:0]      r_pos,      n_pos;
    logic            r_ap,       n_ap;
    logic            r_drop,     n_drop;
    logic            r_south,    n_south;
    logic            r_west,     n_west;
    logic [6:0]      r_lat_deg,  n_lat_deg;
    logic [6:0]      r_lat_mi,   n_lat_mi;
    logic [FR_W-1:0] r_lat_fr,   n_lat_fr;
    logic [2:0]      r_lat_fd,   n_lat_fd;
    logic [9:0]      r_lon_deg,  n_lon_deg;
    logic [6:0]      r_lon_mi,   n_lon_mi;
    logic [FR_W-1:0] r_lon_fr,   n_lon_fr;
    logic [2:0]      r_lon_fd,   n_lon_fd;

    // conversion pipeline
    logic              r_c_valid, r_m_valid, r_q_valid, r_s_valid, r_o_valid;
    logic              en_c, en_m, en_q, en_s, en_o;
    logic              s_acc;
    logic [9:0]        r_c_lat_deg, r_c_lon_deg;
    logic [X_W-1:0]    r_c_lat_x,   r_c_lon_x;
    logic              r_c_south, r_c_west, r_c_drop;
    logic [MAG_W-1:0]  r_m_lat_degs, r_m_lon_degs;
    logic [PROD_W-1:0] r_m_lat_prod, r_m_lon_prod;
    logic              r_m_south, r_m_west, r_m_drop;
    logic [MAG_W-1:0]  r_q_lat_degs, r_q_lon_degs;
    logic [Q_W-1:0]    r_q_lat_q,    r_q_lon_q;
    logic              r_q_south, r_q_west, r_q_drop;
    logic [LATM_W-1:0] r_s_lat_mag;
    logic [LONM_W-1:0] r_s_lon_mag;
    logic              r_s_south, r_s_west, r_s_flag;
    logic [30:0]       r_o_lat;
    logic [31:0]       r_o_lon;
    logic              r_o_flag;

    // coordinate character datapath
    logic                           sel_lat, sel_ns, sel_lon, sel_ew;
    logic                           is_digit;
    logic [3:0]                     dig;
    logic [2:0]                     deg_digits;
    logic [9:0]                     a_deg;
    logic [6:0]                     a_mi;
    logic [FR_W-1:0]                a_fr;
    logic [2:0]                     a_fd;
    logic [nmeapos_pkg::POW10_W-1:0] wgt;
    logic [PROD_W+RCP_W-1:0]        lat_full, lon_full;
    logic [MAG_W-1:0]               lat_sum, lon_sum;
    logic                           lat_sat, lon_sat;

    assign en_o = !r_o_valid || m_axis_tready;
    assign en_s = !r_s_valid || en_o;
    assign en_q = !r_q_valid || en_s;
    assign en_m = !r_m_valid || en_q;
    assign en_c = !r_c_valid || en_m;

    assign s_axis_tready = en_c;
    assign s_acc         = s_axis_tvalid && en_c;
    assign o_cfg_ready   = 1'b1;

    assign sel_lat = {1'b0, r_field} == {1'b0, r_lat_idx};
    assign sel_ns  = {1'b0, r_field} == ({1'b0, r_lat_idx} + 5'd1);
    assign sel_lon = {1'b0, r_field} == ({1'b0, r_lat_idx} + 5'd2);
    assign sel_ew  = {1'b0, r_field} == ({1'b0, r_lat_idx} + 5'd3);

    assign is_digit   = (s_axis_tdata >= nmeapos_pkg::CH_0) && (s_axis_tdata <= nmeapos_pkg::CH_9);
    assign dig        = s_axis_tdata[3:0];
    assign deg_digits = sel_lat ? 3'd2 : 3'd3;

    always_comb begin
        n_field   = r_field;
        n_pos     = r_pos;
        n_ap      = r_ap;
        n_drop    = r_drop;
        n_south   = r_south;
        n_west    = r_west;
        n_lat_deg = r_lat_deg;
        n_lat_mi  = r_lat_mi;
        n_lat_fr  = r_lat_fr;
        n_lat_fd  = r_lat_fd;
        n_lon_deg = r_lon_deg;
        n_lon_mi  = r_lon_mi;
        n_lon_fr  = r_lon_fr;
        n_lon_fd  = r_lon_fd;

        a_deg = sel_lat ? {3'd0, r_lat_deg} : r_lon_deg;
        a_mi  = sel_lat ? r_lat_mi : r_lon_mi;
        a_fr  = sel_lat ? r_lat_fr : r_lon_fr;
        a_fd  = sel_lat ? r_lat_fd : r_lon_fd;
        // first character of a non-empty field restarts the accumulators
        if (r_pos == 5'd0) begin
            a_deg = '0;
            a_mi  = '0;
            a_fr  = '0;
            a_fd  = '0;
        end
        // fraction is kept normalized to FRAC_DIGITS digits
        wgt = nmeapos_pkg::pow10(FDM1_C - a_fd);

        if (s_acc) begin
            if (s_axis_tlast) begin
                n_field = '0;
                n_pos   = '0;
                n_ap    = 1'b0;
                n_drop  = 1'b0;
            end else if (s_axis_tdata == nmeapos_pkg::CH_COMMA) begin
                if (r_field != 4'd15) begin
                    n_field = r_field + 4'd1;
                end
                n_pos = '0;
                n_ap  = 1'b0;
            end else begin
                if (sel_lat || sel_lon) begin
                    if (s_axis_tdata == nmeapos_pkg::CH_POINT && !r_ap) begin
                        n_ap = 1'b1;
                    end else if (!is_digit) begin
                        n_drop = 1'b1;
                    end else if (r_ap) begin
                        if (a_fd < FD_C) begin
                            a_fr = a_fr + FR_W'(wgt * dig);
                            a_fd = a_fd + 3'd1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else if (r_pos < {2'd0, deg_digits}) begin
                        a_deg = 10'(a_deg * 4'd10) + {6'd0, dig};
                    end else if (r_pos < ({2'd0, deg_digits} + 5'd2)) begin
                        a_mi = 7'(a_mi * 4'd10) + {3'd0, dig};
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (sel_lat) begin
                        n_lat_deg = a_deg[6:0];
                        n_lat_mi  = a_mi;
                        n_lat_fr  = a_fr;
                        n_lat_fd  = a_fd;
                    end else begin
                        n_lon_deg = a_deg;
                        n_lon_mi  = a_mi;
                        n_lon_fr  = a_fr;
                        n_lon_fd  = a_fd;
                    end
                end else if (sel_ns) begin
                    n_south = s_axis_tdata == nmeapos_pkg::CH_S;
                end else if (sel_ew) begin
                    n_west = s_axis_tdata == nmeapos_pkg::CH_W;
                end
                if (r_pos != 5'd31) begin
                    n_pos = r_pos + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_idx <= nmeapos_pkg::LAT_INDEX_RST;
            r_field   <= '0;
            r_pos     <= '0;
            r_ap      <= 1'b0;
            r_drop    <= 1'b0;
            r_south   <= 1'b0;
            r_west    <= 1'b0;
            r_lat_deg <= '0;
            r_lat_mi  <= '0;
            r_lat_fr  <= '0;
            r_lat_fd  <= '0;
            r_lon_deg <= '0;
            r_lon_mi  <= '0;
            r_lon_fr  <= '0;
            r_lon_fd  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_lat_idx <= i_cfg_data;
            end
            r_field   <= n_field;
            r_pos     <= n_pos;
            r_ap      <= n_ap;
            r_drop    <= n_drop;
            r_south   <= n_south;
            r_west    <= n_west;
            r_lat_deg <= n_lat_deg;
            r_lat_mi  <= n_lat_mi;
            r_lat_fr  <= n_lat_fr;
            r_lat_fd  <= n_lat_fd;
            r_lon_deg <= n_lon_deg;
            r_lon_mi  <= n_lon_mi;
            r_lon_fr  <= n_lon_fr;
            r_lon_fd  <= n_lon_fd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_c) r_c_valid <= s_acc && s_axis_tlast;
            if (en_m) r_m_valid <= r_c_valid;
            if (en_q) r_q_valid <= r_m_valid;
            if (en_s) r_s_valid <= r_q_valid;
            if (en_o) r_o_valid <= r_s_valid;
        end
    end

    assign lat_full = PROD_W'(r_m_lat_prod) * RCP_C;
    assign lon_full = PROD_W'(r_m_lon_prod) * RCP_C;
    assign lat_sum  = r_q_lat_degs + MAG_W'(r_q_lat_q);
    assign lon_sum  = r_q_lon_degs + MAG_W'(r_q_lon_q);
    assign lat_sat  = lat_sum > LATL_C;
    assign lon_sat  = lon_sum > LONL_C;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_lat_deg <= {3'd0, r_lat_deg};
            r_c_lon_deg <= r_lon_deg;
            r_c_lat_x   <= X_W'(r_lat_mi) * P_C + X_W'(r_lat_fr);
            r_c_lon_x   <= X_W'(r_lon_mi) * P_C + X_W'(r_lon_fr);
            r_c_south   <= r_south;
            r_c_west    <= r_west;
            r_c_drop    <= r_drop;
        end
        if (en_m) begin
            r_m_lat_degs <= MAG_W'(r_c_lat_deg) * DEG_C;
            r_m_lon_degs <= MAG_W'(r_c_lon_deg) * DEG_C;
            r_m_lat_prod <= PROD_W'(r_c_lat_x) * MUL_C;
            r_m_lon_prod <= PROD_W'(r_c_lon_x) * MUL_C;
            r_m_south    <= r_c_south;
            r_m_west     <= r_c_west;
            r_m_drop     <= r_c_drop;
        end
        if (en_q) begin
            r_q_lat_degs <= r_m_lat_degs;
            r_q_lon_degs <= r_m_lon_degs;
            r_q_lat_q    <= Q_W'(lat_full >> SHIFT);
            r_q_lon_q    <= Q_W'(lon_full >> SHIFT);
            r_q_south    <= r_m_south;
            r_q_west     <= r_m_west;
            r_q_drop     <= r_m_drop;
        end
        if (en_s) begin
            r_s_lat_mag <= lat_sat ? LATM_W'(LATL_C) : LATM_W'(lat_sum);
            r_s_lon_mag <= lon_sat ? LONM_W'(LONL_C) : LONM_W'(lon_sum);
            r_s_south   <= r_q_south;
            r_s_west    <= r_q_west;
            r_s_flag    <= r_q_drop || lat_sat || lon_sat;
        end
        if (en_o) begin
            r_o_lat  <= r_s_south ? 31'd0 - 31'(r_s_lat_mag) : 31'(r_s_lat_mag);
            r_o_lon  <= r_s_west  ? 32'd0 - 32'(r_s_lon_mag) : 32'(r_s_lon_mag);
            r_o_flag <= r_s_flag;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_lon, r_o_lat};
    assign m_axis_tuser  = r_o_flag;

endmodule

`default_nettype wire

// ===== rtl/core/nmeapos_checker.sv =====
// Port-level checks for the NMEA position field parser, bound to the core.
// Depends on nmeapos_pkg and nmea_position_field_parser_core.
`timescale 1ns / 1ps
`default_nettype none

module nmeapos_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:0]) <= nmeapos_pkg::LAT_LIMIT)
                       && ($signed(m_axis_tdata[30:0]) >= -nmeapos_pkg::LAT_LIMIT))
        else $error("latitude outside clamp range");

    a_lon_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[62:31]) <= nmeapos_pkg::LON_LIMIT)
                       && ($signed(m_axis_tdata[62:31]) >= -nmeapos_pkg::LON_LIMIT))
        else $error("longitude outside clamp range");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output request right after reset");

endmodule

bind nmea_position_field_parser_core nmeapos_checker u_nmeapos_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
